// File: hdl/gsucf_pkg.sv
`timescale 1ns / 1ps

package gsucf_pkg;

  localparam int unsigned FrameLen  = 9;
  localparam int unsigned ByteIdxW  = 4;   // counts 0..FrameLen-1
  localparam int unsigned QDepth    = 4;
  localparam int unsigned QPtrW     = 2;
  localparam int unsigned QCntW     = 3;

  localparam logic [7:0] START_BYTE   = 8'hFF;
  localparam logic [7:0] ABC_ON_ARG   = 8'hA0;
  localparam logic [7:0] R2000_HI     = 8'h07;
  localparam logic [7:0] R2000_LO     = 8'hD0;
  localparam logic [7:0] R5000_HI     = 8'h13;
  localparam logic [7:0] R5000_LO     = 8'h88;
  localparam logic [7:0] RANGE_5000_B = 8'h88;
  localparam logic [7:0] RANGE_2000_B = 8'hD0;
  localparam logic [15:0] RANGE_5000  = 16'd5000;
  localparam logic [15:0] RANGE_2000  = 16'd2000;

  // configuration register indexes
  localparam logic REG_TIMEOUT = 1'b0;
  localparam logic REG_ADDR    = 1'b1;

  // result kinds (output tuser)
  localparam logic RES_TX   = 1'b0;
  localparam logic RES_DONE = 1'b1;

  typedef enum logic [1:0] {
    KIND_ISSUE = 2'd0,
    KIND_RX    = 2'd1,
    KIND_TICK  = 2'd2
  } kind_e;

  typedef enum logic [3:0] {
    CMD_READ_GAS  = 4'd0,
    CMD_ZERO_CAL  = 4'd1,
    CMD_ABC_ON    = 4'd2,
    CMD_ABC_OFF   = 4'd3,
    CMD_SPAN_CAL  = 4'd4,
    CMD_RANGE2000 = 4'd5,
    CMD_RANGE5000 = 4'd6,
    CMD_GET_RANGE = 4'd7,
    CMD_GET_ABC   = 4'd8
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_TIMEOUT   = 2'd1,
    ST_BAD_FRAME = 2'd2,
    ST_BAD_RANGE = 2'd3
  } status_e;

  // one unit of work handed from the front end to the emitter
  typedef struct packed {
    logic        is_frame;
    logic [3:0]  cmd;
    logic [15:0] ppm;
    logic [7:0]  addr;
    status_e     status;
    logic [15:0] value;
  } job_t;

  function automatic logic [7:0] cmd_code(input logic [3:0] cmd);
    logic [7:0] code;
    unique case (cmd)
      CMD_READ_GAS:  code = 8'h86;
      CMD_ZERO_CAL:  code = 8'h87;
      CMD_ABC_ON:    code = 8'h79;
      CMD_ABC_OFF:   code = 8'h79;
      CMD_SPAN_CAL:  code = 8'h88;
      CMD_RANGE2000: code = 8'h99;
      CMD_RANGE5000: code = 8'h99;
      CMD_GET_RANGE: code = 8'h9B;
      CMD_GET_ABC:   code = 8'h7D;
      default:       code = 8'h00;
    endcase
    return code;
  endfunction

  // argument bytes 3 and 4 of a request frame
  function automatic logic [15:0] cmd_args(input logic [3:0] cmd, input logic [15:0] ppm);
    logic [15:0] args;
    unique case (cmd)
      CMD_ABC_ON:    args = {ABC_ON_ARG, 8'h00};
      CMD_SPAN_CAL:  args = ppm;
      CMD_RANGE2000: args = {R2000_HI, R2000_LO};
      CMD_RANGE5000: args = {R5000_HI, R5000_LO};
      default:       args = 16'h0000;
    endcase
    return args;
  endfunction

  function automatic logic [7:0] frame_byte(input logic [ByteIdxW-1:0] idx,
                                            input job_t job);
    logic [7:0]  code;
    logic [15:0] args;
    logic [7:0]  sum;
    logic [7:0]  b;
    code = cmd_code(job.cmd);
    args = cmd_args(job.cmd, job.ppm);
    sum  = job.addr + code + args[15:8] + args[7:0];
    unique case (idx)
      4'd0:    b = START_BYTE;
      4'd1:    b = job.addr;
      4'd2:    b = code;
      4'd3:    b = args[15:8];
      4'd4:    b = args[7:0];
      4'd8:    b = 8'h00 - sum;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// File: hdl/gsucf_front.sv
`timescale 1ns / 1ps

module gsucf_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic                 cfg_idx_i,
  input  logic [15:0]          cfg_wdata_i,
  input  logic                 in_fire_i,
  input  logic [1:0]           kind_i,
  input  logic [3:0]           cmd_i,
  input  logic [15:0]          ppm_i,
  input  logic [7:0]           rx_i,
  output logic                 push_o,
  output gsucf_pkg::job_t      job_o
);
  import gsucf_pkg::*;

  logic [15:0]         timeout_q, elapsed_q, elapsed_d;
  logic [7:0]          addr_q;
  logic                busy_q, busy_d;
  logic [3:0]          pend_q, pend_d;
  logic [ByteIdxW-1:0] cnt_q, cnt_d;
  logic [7:0]          sum_q, sum_d;
  logic [7:0]          reply_q [8];
  logic                store_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= 16'd50;
      addr_q    <= 8'd1;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == REG_TIMEOUT) timeout_q <= cfg_wdata_i;
      if (cfg_idx_i == REG_ADDR)    addr_q    <= cfg_wdata_i[7:0];
    end
  end

  always_comb begin
    busy_d    = busy_q;
    pend_d    = pend_q;
    cnt_d     = cnt_q;
    sum_d     = sum_q;
    elapsed_d = elapsed_q;
    store_en  = 1'b0;
    push_o    = 1'b0;
    job_o     = '{is_frame: 1'b0, cmd: cmd_i, ppm: ppm_i, addr: addr_q,
                  status: ST_OK, value: 16'h0000};
    if (in_fire_i) begin
      unique case (kind_i)
        KIND_ISSUE: begin
          if (!busy_q && cmd_i <= CMD_GET_ABC) begin
            push_o         = 1'b1;
            job_o.is_frame = 1'b1;
            busy_d         = 1'b1;
            pend_d         = cmd_i;
            cnt_d          = '0;
            sum_d          = 8'h00;
            elapsed_d      = 16'h0000;
          end
        end
        KIND_RX: begin
          if (busy_q) begin
            store_en = (cnt_q < ByteIdxW'(FrameLen - 1));
            if (cnt_q != '0 && store_en) sum_d = sum_q + rx_i;
            cnt_d = cnt_q + 1'b1;
            if (cnt_q == ByteIdxW'(FrameLen - 1)) begin
              // ninth byte: check and report
              push_o    = 1'b1;
              busy_d    = 1'b0;
              cnt_d     = '0;
              elapsed_d = 16'h0000;
              if (reply_q[0] != START_BYTE || reply_q[1] != cmd_code(pend_q) ||
                  rx_i != 8'h00 - sum_q) begin
                job_o.status = ST_BAD_FRAME;
              end else if (pend_q == CMD_READ_GAS) begin
                job_o.value = {reply_q[2], reply_q[3]};
              end else if (pend_q == CMD_GET_RANGE) begin
                if (reply_q[2] == RANGE_5000_B)      job_o.value  = RANGE_5000;
                else if (reply_q[2] == RANGE_2000_B) job_o.value  = RANGE_2000;
                else                                 job_o.status = ST_BAD_RANGE;
              end else if (pend_q == CMD_GET_ABC) begin
                job_o.value = {8'h00, reply_q[7]};
              end
            end
          end
        end
        KIND_TICK: begin
          if (busy_q) begin
            if (elapsed_q != 16'hFFFF) elapsed_d = elapsed_q + 16'd1;
            if (elapsed_d >= timeout_q) begin
              push_o       = 1'b1;
              job_o.status = ST_TIMEOUT;
              busy_d       = 1'b0;
              cnt_d        = '0;
              elapsed_d    = 16'h0000;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      pend_q    <= '0;
      cnt_q     <= '0;
      sum_q     <= '0;
      elapsed_q <= '0;
    end else begin
      busy_q    <= busy_d;
      pend_q    <= pend_d;
      cnt_q     <= cnt_d;
      sum_q     <= sum_d;
      elapsed_q <= elapsed_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (store_en) reply_q[cnt_q[2:0]] <= rx_i;
  end

endmodule

// File: hdl/gsucf_fifo.sv
`timescale 1ns / 1ps

module gsucf_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  gsucf_pkg::job_t job_i,
  output logic            full_o,
  output logic            valid_o,
  input  logic            pop_i,
  output gsucf_pkg::job_t job_o
);
  import gsucf_pkg::*;

  job_t             mem_q [QDepth];
  logic [QPtrW-1:0] wr_q, rd_q;
  logic [QCntW-1:0] cnt_q;

  assign full_o  = (cnt_q == QCntW'(QDepth));
  assign valid_o = (cnt_q != '0);
  assign job_o   = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i)  rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + QCntW'(push_i) - QCntW'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= job_i;
  end

endmodule

// File: hdl/gsucf_back.sv
`timescale 1ns / 1ps

module gsucf_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            job_valid_i,
  input  gsucf_pkg::job_t job_i,
  output logic            pop_o,
  output logic            valid_o,
  input  logic            ready_i,
  output logic            kind_o,
  output logic            last_o,
  output logic [7:0]      tx_o,
  output logic [1:0]      status_o,
  output logic [15:0]     value_o
);
  import gsucf_pkg::*;

  logic [ByteIdxW-1:0] idx_q;
  logic                valid_q;
  logic                load;
  logic                frame_end;

  assign load      = job_valid_i && (!valid_q || ready_i);
  assign frame_end = (idx_q == ByteIdxW'(FrameLen - 1));
  assign pop_o     = load && (!job_i.is_frame || frame_end);
  assign valid_o   = valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      if (load)         valid_q <= 1'b1;
      else if (ready_i) valid_q <= 1'b0;
      if (load && job_i.is_frame) idx_q <= frame_end ? '0 : idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      if (job_i.is_frame) begin
        kind_o   <= RES_TX;
        tx_o     <= frame_byte(idx_q, job_i);
        last_o   <= frame_end;
        status_o <= ST_OK;
        value_o  <= 16'h0000;
      end else begin
        kind_o   <= RES_DONE;
        tx_o     <= 8'h00;
        last_o   <= 1'b0;
        status_o <= job_i.status;
        value_o  <= job_i.value;
      end
    end
  end

endmodule

// File: hdl/gas_sensor_uart_command_frames.sv
`timescale 1ns / 1ps
// Channel   Dir  Handshake              Payload
// s_axis    in   tvalid/tready          tuser: kind; tdata: command, span_ppm, rx_byte
// m_axis    out  tvalid/tready/tlast    tuser: result_kind; tdata: tx_byte, status, value
// cfg       in   cfg_we_i (no ready)    cfg_idx_i selects register, cfg_wdata_i data
//
// One input transaction per cycle while the job queue has room (four entries).
// An issue produces nine output transactions, one per cycle from the emitter while
// m_axis_tready is high; a completion produces one. Output ready sets pacing.
// Decode of the reply happens at the ninth received byte in the front end.
// Reset is asynchronous, active low; it clears control state and restores
// timeout_ticks = 50 and device_address = 1.
// Output stalls fill the queue; input stalls only when the queue is full.

module gas_sensor_uart_command_frames (
  input  logic        clk_i,
  input  logic        rst_ni,
  // config write port
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [3:0] command, [19:4] span_ppm, [27:20] rx_byte
  input  logic [1:0]  s_axis_tuser,   // [1:0] kind
  // output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [7:0] tx_byte, [9:8] status, [25:10] value
  output logic        m_axis_tuser,   // [0] result_kind
  output logic        m_axis_tlast
);
  import gsucf_pkg::*;

  logic        q_full, q_valid, push, pop, in_fire;
  job_t        push_job, head_job;
  logic [7:0]  tx;
  logic [1:0]  status;
  logic [15:0] value;

  assign s_axis_tready = !q_full;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  // front end: classify transaction, track reply, queue work
  gsucf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_fire_i   (in_fire),
    .kind_i      (s_axis_tuser),
    .cmd_i       (s_axis_tdata[3:0]),
    .ppm_i       (s_axis_tdata[19:4]),
    .rx_i        (s_axis_tdata[27:20]),
    .push_o      (push),
    .job_o       (push_job)
  );

  gsucf_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .full_o  (q_full),
    .valid_o (q_valid),
    .pop_i   (pop),
    .job_o   (head_job)
  );

  // back end: expand frames into bytes, emit completions
  gsucf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (q_valid),
    .job_i       (head_job),
    .pop_o       (pop),
    .valid_o     (m_axis_tvalid),
    .ready_i     (m_axis_tready),
    .kind_o      (m_axis_tuser),
    .last_o      (m_axis_tlast),
    .tx_o        (tx),
    .status_o    (status),
    .value_o     (value)
  );

  assign m_axis_tdata = {6'b000000, value, status, tx};

endmodule

// File: hdl/gsucf_checker.sv
`timescale 1ns / 1ps

module gsucf_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic        m_axis_tuser,
  input logic        m_axis_tlast
);
  import gsucf_pkg::*;

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("output changed while stalled");

  a_last_is_tx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tuser == RES_TX)
    else $error("tlast on a completion");

  a_tx_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == RES_TX |-> m_axis_tdata[31:8] == 24'h0)
    else $error("request byte with status or value");

  a_err_no_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == RES_DONE && m_axis_tdata[9:8] != ST_OK
      |-> m_axis_tdata[25:10] == 16'h0 && m_axis_tdata[7:0] == 8'h0)
    else $error("error completion carries data");

endmodule

bind gas_sensor_uart_command_frames gsucf_checker u_gsucf_checker (.*);

// File: verif/gas_frame_checker.sv
`timescale 1ns / 1ps

package gas_frame_tb_pkg;
  import gsucf_pkg::*;

  // byte 0 first: frame[i] is byte i on the wire
  typedef logic [8:0][7:0] frame_t;

  function automatic logic [7:0] opcode_byte(input logic [3:0] cmd);
    case (cmd)
      CMD_READ_GAS:  return 8'h86;
      CMD_ZERO_CAL:  return 8'h87;
      CMD_ABC_ON,
      CMD_ABC_OFF:   return 8'h79;
      CMD_SPAN_CAL:  return 8'h88;
      CMD_RANGE2000,
      CMD_RANGE5000: return 8'h99;
      CMD_GET_RANGE: return 8'h9B;
      CMD_GET_ABC:   return 8'h7D;
      default:       return 8'h00;
    endcase
  endfunction

  // negated byte sum over bytes 1..7
  function automatic logic [7:0] checksum_of(input frame_t f);
    logic [7:0] acc;
    acc = 8'h00;
    for (int i = 1; i < 8; i++) acc = acc + f[i];
    return 8'h00 - acc;
  endfunction

endpackage

module gas_frame_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,
  input  logic [1:0]  s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [31:0] m_axis_tdata,
  input  logic        m_axis_tuser,
  input  logic        m_axis_tlast,
  output int          errors_o,
  output int          outstanding_o,
  output int          checked_o
);
  import gsucf_pkg::*;
  import gas_frame_tb_pkg::*;

  typedef struct packed {
    logic        done;
    logic [7:0]  tx;
    logic        last;
    logic [1:0]  status;
    logic [15:0] value;
  } sensor_result_t;

  sensor_result_t expected_out[$];
  sensor_result_t want;

  // shadow of the block's registers and protocol state
  logic [15:0] timeout_q;
  logic [7:0]  addr_q;
  logic        busy_q;
  logic [3:0]  cmd_q;
  logic [3:0]  nrx_q;
  frame_t      reply_q;
  logic [15:0] ticks_q;

  function automatic sensor_result_t make_result(input logic done, input logic [7:0] tx,
                                                 input logic last, input status_e status,
                                                 input logic [15:0] value);
    sensor_result_t r;
    r.done   = done;
    r.tx     = tx;
    r.last   = last;
    r.status = status;
    r.value  = value;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] seen,
                                 input logic [31:0] wanted);
    $display("%0t checker: result %0d %s: got 0x%0h, want 0x%0h",
             $time, checked_o, what, seen, wanted);
    errors_o++;
  endtask

  task automatic predict_item(input logic [1:0] kind, input logic [3:0] cmd,
                              input logic [15:0] ppm, input logic [7:0] rx);
    frame_t      req;
    status_e     status;
    logic [15:0] value;
    case (kind)
      KIND_ISSUE: begin
        if (!busy_q && cmd <= CMD_GET_ABC) begin
          req    = '0;
          req[0] = START_BYTE;
          req[1] = addr_q;
          req[2] = opcode_byte(cmd);
          case (cmd)
            CMD_ABC_ON:    req[3] = 8'hA0;
            CMD_SPAN_CAL:  {req[3], req[4]} = ppm;
            CMD_RANGE2000: {req[3], req[4]} = 16'h07D0;
            CMD_RANGE5000: {req[3], req[4]} = 16'h1388;
            default: ;
          endcase
          req[8] = checksum_of(req);
          for (int i = 0; i < 9; i++)
            expected_out.push_back(make_result(RES_TX, req[i], i == 8, ST_OK, 16'h0000));
          busy_q  = 1'b1;
          cmd_q   = cmd;
          nrx_q   = '0;
          ticks_q = '0;
        end
      end
      KIND_RX: begin
        if (busy_q) begin
          reply_q[nrx_q] = rx;
          nrx_q = nrx_q + 1'b1;
          if (nrx_q == 4'd9) begin
            status = ST_OK;
            value  = 16'h0000;
            if (reply_q[0] != START_BYTE || reply_q[1] != opcode_byte(cmd_q) ||
                reply_q[8] != checksum_of(reply_q)) begin
              status = ST_BAD_FRAME;
            end else if (cmd_q == CMD_READ_GAS) begin
              value = {reply_q[2], reply_q[3]};
            end else if (cmd_q == CMD_GET_RANGE) begin
              if (reply_q[2] == RANGE_5000_B) value = RANGE_5000;
              else if (reply_q[2] == RANGE_2000_B) value = RANGE_2000;
              else status = ST_BAD_RANGE;
            end else if (cmd_q == CMD_GET_ABC) begin
              value = {8'h00, reply_q[7]};
            end
            expected_out.push_back(make_result(RES_DONE, 8'h00, 1'b0, status, value));
            busy_q  = 1'b0;
            nrx_q   = '0;
            ticks_q = '0;
          end
        end
      end
      KIND_TICK: begin
        if (busy_q) begin
          if (ticks_q != 16'hFFFF) ticks_q = ticks_q + 1'b1;
          if (ticks_q >= timeout_q) begin
            expected_out.push_back(make_result(RES_DONE, 8'h00, 1'b0, ST_TIMEOUT, 16'h0000));
            busy_q  = 1'b0;
            nrx_q   = '0;
            ticks_q = '0;
          end
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_out.delete();
      timeout_q = 16'd50;
      addr_q    = 8'd1;
      busy_q    = 1'b0;
      cmd_q     = '0;
      nrx_q     = '0;
      reply_q   = '0;
      ticks_q   = '0;
      errors_o  = 0;
      checked_o = 0;
      outstanding_o <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_out.size() == 0) begin
          report_mismatch("arrived with nothing expected, tdata", m_axis_tdata, '0);
        end else begin
          want = expected_out.pop_front();
          if (m_axis_tuser !== want.done)
            report_mismatch("result_kind", 32'(m_axis_tuser), 32'(want.done));
          if (m_axis_tdata[7:0] !== want.tx)
            report_mismatch("tx_byte", 32'(m_axis_tdata[7:0]), 32'(want.tx));
          if (m_axis_tlast !== want.last)
            report_mismatch("last", 32'(m_axis_tlast), 32'(want.last));
          if (m_axis_tdata[9:8] !== want.status)
            report_mismatch("status", 32'(m_axis_tdata[9:8]), 32'(want.status));
          if (m_axis_tdata[25:10] !== want.value)
            report_mismatch("value", 32'(m_axis_tdata[25:10]), 32'(want.value));
          checked_o++;
        end
      end
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_TIMEOUT) timeout_q = cfg_wdata_i;
        else addr_q = cfg_wdata_i[7:0];
      end
      if (s_axis_tvalid && s_axis_tready)
        predict_item(s_axis_tuser, s_axis_tdata[3:0], s_axis_tdata[19:4],
                     s_axis_tdata[27:20]);
      outstanding_o <= expected_out.size();
    end
  end

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import gsucf_pkg::*;
  import gas_frame_tb_pkg::*;

  // quiet cycles tolerated: squeeze hold + longest stall/gap, with margin
  localparam int         WATCHDOG_CYCLES = 4000;
  // cycles left for queued items that cause no result before touching registers
  localparam int         DRAIN_CYCLES    = 16;
  localparam int         SQUEEZE_CYCLES  = 400;
  localparam logic [1:0] KIND_UNUSED     = 2'd3;
  localparam logic [3:0] CMD_BEYOND      = 4'hF;

  typedef enum int {
    FAULT_NONE,
    FAULT_START,
    FAULT_OPCODE,
    FAULT_CHECKSUM,
    FAULT_SHORT
  } fault_e;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic        cfg_idx_i;
  logic [15:0] cfg_wdata_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;   // [3:0] command, [19:4] span_ppm, [27:20] rx_byte
  logic [1:0]  s_axis_tuser;   // [1:0] kind
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;   // [7:0] tx_byte, [9:8] status, [25:10] value
  logic        m_axis_tuser;   // [0] result_kind
  logic        m_axis_tlast;

  int          errors;
  int          outstanding;
  int          checked;
  int          items_sent;
  int          settings_used;
  int          quiet_cycles;
  logic [15:0] cur_timeout;
  bit          burst;          // sender runs back to back while set
  bit          squeeze_req;
  bit          squeeze_done;

  always #5 clk_i = ~clk_i;

  gas_sensor_uart_command_frames u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  gas_frame_checker u_chk (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .errors_o      (errors),
    .outstanding_o (outstanding),
    .checked_o     (checked)
  );

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [15:0] rand_ppm();
    return 16'($urandom_range(0, 65535));
  endfunction

  function automatic logic [3:0] rand_cmd(input int lo, input int hi);
    return 4'($urandom_range(lo, hi));
  endfunction

  // One input transaction. Valid stays high on return so a following
  // back-to-back transaction never drops and re-raises it in one step.
  task automatic push_item(input logic [1:0] kind, input logic [3:0] cmd,
                           input logic [15:0] ppm, input logic [7:0] rx);
    int pick;
    int gap;
    pick = $urandom_range(0, 99);
    if (burst || pick < 60) gap = 0;
    else if (pick < 92) gap = $urandom_range(1, 3);
    else gap = $urandom_range(4, 40);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {4'h0, rx, ppm, cmd};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic push_tick();
    push_item(KIND_TICK, rand_cmd(0, 15), rand_ppm(), rand_byte());
  endtask

  // Registers only change with nothing in flight; both are written each time.
  task automatic set_config(input logic [15:0] ticks, input logic [7:0] addr);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= REG_TIMEOUT;
    cfg_wdata_i <= ticks;
    @(posedge clk_i);
    cfg_idx_i   <= REG_ADDR;
    cfg_wdata_i <= {8'h00, addr};
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    @(posedge clk_i);
    cur_timeout = ticks;
    settings_used++;
  endtask

  // Well-formed reply: start byte, echoed opcode, random payload, good checksum.
  function automatic frame_t reply_frame(input logic [3:0] cmd, input logic [7:0] b2);
    frame_t r;
    r[0] = START_BYTE;
    r[1] = opcode_byte(cmd);
    r[2] = b2;
    for (int i = 3; i < 8; i++) r[i] = rand_byte();
    r[8] = checksum_of(r);
    return r;
  endfunction

  // Feed the first n reply bytes; a rough reply sprinkles in ticks and stray issues.
  task automatic send_reply(input frame_t r, input int n, input bit rough);
    for (int i = 0; i < n; i++) begin
      if (rough && $urandom_range(0, 9) == 0) push_tick();
      if (rough && $urandom_range(0, 24) == 0)
        push_item(KIND_ISSUE, rand_cmd(0, 8), rand_ppm(), rand_byte());
      push_item(KIND_RX, rand_cmd(0, 15), rand_ppm(), r[i]);
    end
  endtask

  task automatic answer(input logic [3:0] cmd, input bit rough);
    frame_t     r;
    fault_e     fault;
    int         pick;
    int         n;
    logic [7:0] flip;
    logic [7:0] b2;
    b2 = rand_byte();
    // range query: mostly the two known codes, sometimes junk
    if (cmd == CMD_GET_RANGE) begin
      case ($urandom_range(0, 2))
        0:       b2 = RANGE_5000_B;
        1:       b2 = RANGE_2000_B;
        default: ;
      endcase
    end
    r     = reply_frame(cmd, b2);
    pick  = $urandom_range(0, 9);
    fault = (rough && pick <= FAULT_SHORT) ? fault_e'(pick) : FAULT_NONE;
    flip  = 8'($urandom_range(1, 255));
    n     = 9;
    case (fault)
      FAULT_START:    r[0] = r[0] ^ flip;
      FAULT_OPCODE:   r[1] = r[1] ^ flip;
      FAULT_CHECKSUM: r[8] = r[8] ^ flip;
      FAULT_SHORT: begin
        // a cut-off reply only pays off while the timeout is short
        if (cur_timeout <= 60) n = $urandom_range(0, 8);
        else r[8] = r[8] ^ flip;
      end
      default: ;
    endcase
    send_reply(r, n, rough);
    if (n < 9) repeat (cur_timeout) push_tick();
  endtask

  // Mostly command/reply exchanges with random content, the rest single noise items.
  task automatic run_traffic(input int n);
    int         stop;
    logic [3:0] cmd;
    stop = items_sent + n;
    while (items_sent < stop) begin
      burst = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 4) == 0) begin
        case ($urandom_range(0, 4))
          0: push_item(KIND_RX, rand_cmd(0, 15), rand_ppm(), rand_byte());
          1: push_tick();
          2: push_item(KIND_UNUSED, rand_cmd(0, 15), rand_ppm(), rand_byte());
          3: push_item(KIND_ISSUE, rand_cmd(9, 15), rand_ppm(), rand_byte());
          default: push_item(KIND_ISSUE, rand_cmd(0, 8), rand_ppm(), rand_byte());
        endcase
      end else begin
        cmd = rand_cmd(0, 8);
        push_item(KIND_ISSUE, cmd, rand_ppm(), rand_byte());
        answer(cmd, 1'b1);
      end
    end
    burst = 1'b0;
  endtask

  // Close any open command with nine junk bytes, wait for all results,
  // then give queued no-result items time to leave the block.
  task automatic wrap_up();
    repeat (9) push_item(KIND_RX, rand_cmd(0, 15), rand_ppm(), rand_byte());
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Output side: random ready/stall runs, plus one long hold on request so
  // the job queue fills and the input side backs up.
  initial begin
    m_axis_tready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if (squeeze_req && !squeeze_done) begin
        m_axis_tready <= 1'b0;
        repeat (SQUEEZE_CYCLES) @(posedge clk_i);
        squeeze_done = 1'b1;
      end else begin
        m_axis_tready <= 1'b1;
        repeat (($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 30)) @(posedge clk_i);
        m_axis_tready <= 1'b0;
        repeat (($urandom_range(0, 9) == 0) ? $urandom_range(4, 60) : $urandom_range(1, 3))
          @(posedge clk_i);
      end
    end
  end

  // Watchdog: any accepted transaction or register write counts as progress.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        cfg_we_i) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_CYCLES) begin
      $display("testbench: no progress for %0d cycles, %0d results still owed",
               quiet_cycles, outstanding);
      $display("testbench: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= REG_TIMEOUT;
    cfg_wdata_i   <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= KIND_ISSUE;
    items_sent    = 0;
    settings_used = 1;
    cur_timeout   = 16'd50;
    burst         = 1'b0;
    squeeze_req   = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed, reset register values (timeout 50, address 1)
    push_item(KIND_RX, CMD_READ_GAS, 16'h0000, 8'hFF);       // byte while idle
    push_item(KIND_TICK, CMD_READ_GAS, 16'h0000, 8'h00);     // tick while idle
    push_item(KIND_UNUSED, CMD_BEYOND, 16'hFFFF, 8'hFF);     // undefined kind
    push_item(KIND_ISSUE, CMD_BEYOND, 16'hFFFF, 8'h00);      // opcode out of range
    push_item(KIND_ISSUE, CMD_SPAN_CAL, 16'hFFFF, 8'h00);    // span, all-ones ppm
    push_item(KIND_ISSUE, CMD_READ_GAS, 16'h0000, 8'h00);    // issue while busy
    answer(CMD_SPAN_CAL, 1'b0);
    push_item(KIND_ISSUE, CMD_GET_RANGE, 16'h0000, 8'h00);
    send_reply(reply_frame(CMD_GET_RANGE, 8'h00), 9, 1'b0);  // unknown range code

    // random traffic under the reset settings, with the long output hold
    squeeze_req = 1'b1;
    run_traffic(30);
    wrap_up();

    // shortest timeout, address zero: any tick while busy times out
    set_config(16'd1, 8'h00);
    run_traffic(12);
    wrap_up();

    // longest timeout, address all ones: ticks pass without a timeout
    set_config(16'hFFFF, 8'hFF);
    push_item(KIND_ISSUE, CMD_READ_GAS, 16'h0000, 8'h00);
    repeat (8) push_tick();
    answer(CMD_READ_GAS, 1'b0);
    run_traffic(12);
    wrap_up();

    set_config(16'($urandom_range(2, 24)), rand_byte());
    run_traffic(15);
    wrap_up();

    set_config(16'($urandom_range(25, 300)), rand_byte());
    run_traffic(12);
    wrap_up();

    $display("testbench: %0d input transactions over %0d register settings, %0d results checked",
             items_sent, settings_used, checked);
    $display("testbench: covered all nine commands, faulty and cut-off replies,");
    $display("testbench: timeouts and a full output hold");
    if (errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
